[rtl/dfs_pkg.sv]
// ----------------------------------------------------------------------------
// dfs_pkg
// shared types and constants for the delimiter field splitter
// ----------------------------------------------------------------------------
package dfs_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_DELIM_BYTES  = 2'd0,
    CFG_DELIM_LENGTH = 2'd1,
    CFG_IGNORE_EMPTY = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0] delim_bytes;
    logic [3:0]  delim_length;
    logic        ignore_empty;
  } cfg_t;

  typedef struct packed {
    logic [15:0] piece_start;
    logic [15:0] piece_length;
    logic [15:0] piece_number;
    logic        final_piece;
  } piece_t;

  // up to two pieces per item, slot0 first
  typedef struct packed {
    logic [1:0] count;
    piece_t     slot0;
    piece_t     slot1;
  } push_t;

endpackage

[rtl/dfs_in_if.sv]
// ----------------------------------------------------------------------------
// dfs_in_if
// text byte channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface dfs_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  text_byte;
  logic        final_byte;
  logic [15:0] text_length;

  modport source (output valid, text_byte, final_byte, text_length, input ready);
  modport sink   (input valid, text_byte, final_byte, text_length, output ready);
endinterface

[rtl/dfs_out_if.sv]
// ----------------------------------------------------------------------------
// dfs_out_if
// piece descriptor channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface dfs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] piece_start;
  logic [15:0] piece_length;
  logic [15:0] piece_number;
  logic        final_piece;

  modport source (output valid, piece_start, piece_length, piece_number, final_piece,
                  input ready);
  modport sink   (input valid, piece_start, piece_length, piece_number, final_piece,
                  output ready);
endinterface

[rtl/dfs_matcher.sv]
// ----------------------------------------------------------------------------
// dfs_matcher
// delimiter match state and piece descriptor generation, one byte per cycle while accept_i is high
// ----------------------------------------------------------------------------
module dfs_matcher
  import dfs_pkg::*;
#(
  parameter int unsigned MAX_DELIMITER = 8,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  text_byte_i,
  input  logic        final_byte_i,
  input  logic [15:0] text_length_i,
  input  cfg_t        cfg_i,
  output push_t       push_o
);

  localparam int unsigned PosW = POSITION_BITS;

  logic [3:0]      match_q, match_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] start_q, start_d;
  logic [15:0]     emitted_q, emitted_d;

  logic [3:0]      dlen;
  logic            dlen_nz;
  logic            allow;
  logic [7:0]      cur_byte;
  logic            hit;
  logic [3:0]      match_step;
  logic            full;
  logic [PosW-1:0] pos_inc;
  logic [PosW-1:0] len_delim;
  logic [PosW-1:0] start_after;
  logic [PosW-1:0] len_final;
  logic            emit_delim;
  logic            emit_final;
  piece_t          piece_delim;
  piece_t          piece_final;

  always_comb begin
    dlen     = (cfg_i.delim_length > 4'(MAX_DELIMITER)) ? 4'(MAX_DELIMITER)
                                                         : cfg_i.delim_length;
    dlen_nz  = (dlen != 4'd0);
    allow    = dlen_nz && ({12'd0, dlen} < text_length_i);
    cur_byte = cfg_i.delim_bytes[{match_q[2:0], 3'b000} +: 8];
    hit      = (match_q < dlen) && (text_byte_i == cur_byte);
    // on a miss the byte is tried again against delimiter byte 0
    if (hit) begin
      match_step = match_q + 4'd1;
    end else if (text_byte_i == cfg_i.delim_bytes[7:0]) begin
      match_step = 4'd1;
    end else begin
      match_step = 4'd0;
    end
    full        = dlen_nz && (match_step >= dlen);
    pos_inc     = pos_q + PosW'(1);
    len_delim   = pos_inc - PosW'(dlen) - start_q;
    start_after = full ? pos_inc : start_q;
    len_final   = pos_inc - start_after;
    emit_delim  = allow && full && !((len_delim == '0) && cfg_i.ignore_empty);
    emit_final  = allow && final_byte_i && !((len_final == '0) && cfg_i.ignore_empty);

    piece_delim.piece_start  = 16'(start_q);
    piece_delim.piece_length = 16'(len_delim);
    piece_delim.piece_number = emitted_q;
    piece_delim.final_piece  = 1'b0;

    piece_final.piece_start  = 16'(start_after);
    piece_final.piece_length = 16'(len_final);
    piece_final.piece_number = emitted_q + {15'd0, emit_delim};
    piece_final.final_piece  = 1'b1;

    push_o.count = accept_i ? ({1'b0, emit_delim} + {1'b0, emit_final}) : 2'd0;
    push_o.slot0 = emit_delim ? piece_delim : piece_final;
    push_o.slot1 = piece_final;

    if (final_byte_i) begin
      match_d   = 4'd0;
      pos_d     = '0;
      start_d   = '0;
      emitted_d = 16'd0;
    end else begin
      match_d   = !dlen_nz ? match_q : (full ? 4'd0 : match_step);
      pos_d     = pos_inc;
      start_d   = start_after;
      emitted_d = emitted_q + {15'd0, emit_delim};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q   <= 4'd0;
      pos_q     <= '0;
      start_q   <= '0;
      emitted_q <= 16'd0;
    end else if (accept_i) begin
      match_q   <= match_d;
      pos_q     <= pos_d;
      start_q   <= start_d;
      emitted_q <= emitted_d;
    end
  end

endmodule

[rtl/dfs_queue.sv]
// ----------------------------------------------------------------------------
// dfs_queue
// small result queue, takes up to two pieces per cycle and hands out one
// ----------------------------------------------------------------------------
module dfs_queue
  import dfs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  push_t                push_i,
  input  logic                 pop_i,
  output piece_t               head_o,
  output logic [QueueCntW-1:0] level_o
);

  piece_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, wr_d;
  logic [QueuePtrW-1:0] rd_q, rd_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic [QueuePtrW-1:0] wr_next;

  always_comb begin
    wr_next = wr_q + QueuePtrW'(1);
    wr_d    = wr_q + QueuePtrW'(push_i.count);
    rd_d    = pop_i ? rd_q + QueuePtrW'(1) : rd_q;
    cnt_d   = cnt_q + QueueCntW'(push_i.count) - QueueCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.slot0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.slot1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign head_o  = mem_q[rd_q];
  assign level_o = cnt_q;

endmodule

[rtl/delimiter_field_splitter.sv]
// ----------------------------------------------------------------------------
// delimiter_field_splitter
// splits a byte stream at a multi-byte delimiter into piece descriptors
// ----------------------------------------------------------------------------
//  channel    dir  handshake          payload
//  text_if    in   valid/ready        text_byte, final_byte, text_length
//  piece_if   out  valid/ready        piece_start, piece_length, piece_number,
//                                     final_piece
//  cfg        in   cfg_we_i           cfg_idx_i, cfg_wdata_i
//
//  one byte item per cycle while text_if.ready is high: the delimiter compare and
//  the offset arithmetic sit between the match state registers and a four-entry result queue
//  a byte item gives zero, one or two pieces; the first piece can be taken
//  in the cycle after its byte is accepted
//  text_if.ready is low only while fewer than two queue entries are free
//  reset clears match state, counters and queue; configuration resets to a one-byte zero delimiter
module delimiter_field_splitter
  import dfs_pkg::*;
#(
  parameter int unsigned MAX_DELIMITER = 8,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dfs_in_if.sink       text_if,
  dfs_out_if.source    piece_if,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [63:0]  cfg_wdata_i
);

  cfg_t                 cfg_q;
  push_t                push;
  piece_t               head;
  logic [QueueCntW-1:0] level;
  logic                 in_accept;
  logic                 out_accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delim_bytes  <= 64'd0;
      cfg_q.delim_length <= 4'd1;
      cfg_q.ignore_empty <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DELIM_BYTES:  cfg_q.delim_bytes  <= cfg_wdata_i;
        CFG_DELIM_LENGTH: cfg_q.delim_length <= cfg_wdata_i[3:0];
        CFG_IGNORE_EMPTY: cfg_q.ignore_empty <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // two free entries cover the worst case of a delimiter piece plus a final piece
  assign text_if.ready = (level <= QueueCntW'(QueueDepth - 2));
  assign in_accept     = text_if.valid && text_if.ready;
  assign out_accept    = piece_if.valid && piece_if.ready;

  dfs_matcher #(
    .MAX_DELIMITER (MAX_DELIMITER),
    .POSITION_BITS (POSITION_BITS)
  ) u_matcher (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .text_byte_i   (text_if.text_byte),
    .final_byte_i  (text_if.final_byte),
    .text_length_i (text_if.text_length),
    .cfg_i         (cfg_q),
    .push_o        (push)
  );

  dfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_accept),
    .head_o  (head),
    .level_o (level)
  );

  assign piece_if.valid        = (level != '0);
  assign piece_if.piece_start  = head.piece_start;
  assign piece_if.piece_length = head.piece_length;
  assign piece_if.piece_number = head.piece_number;
  assign piece_if.final_piece  = head.final_piece;

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= QueueCntW'(QueueDepth))
    else $error("result queue overflow");

  a_room_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> (level <= QueueCntW'(QueueDepth - 2)))
    else $error("byte accepted without room for two pieces");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.count == 2'd2) |-> (push.slot1.final_piece && !push.slot0.final_piece))
    else $error("delimiter piece must precede final piece");

  a_level_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (level == $past(level) + QueueCntW'($past(push.count))
                       - QueueCntW'($past(out_accept))))
    else $error("queue level does not follow push and pop");

endmodule

[tb/delimiter_field_splitter_tb.sv]
// ----------------------------------------------------------------------------
// delimiter_field_splitter_tb
// self-checking bench: a directed table, then random texts under changing
// delimiter settings, then one text with sparse letters among zero delimiters and no idling;
// every piece is checked against the table's golden values or a cycle-free model of the splitter
// ----------------------------------------------------------------------------
module delimiter_field_splitter_tb
  import dfs_pkg::*;
;

  localparam int unsigned MaxDelim     = 8;
  localparam int          SettleCycles = 16;
  localparam int          MaxReports   = 50;
  localparam int          SweepBytes   = 40;
  localparam logic [31:0] FillerBytes  = 32'hFF002D2C;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    cfg_idx_e    idx;
    logic [63:0] wdata;
    logic [7:0]  text_byte;
    logic        final_byte;
    logic [15:0] text_length;
    int          golden_n;  // -1: take the model's pieces
    piece_t      g0;
    piece_t      g1;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [63:0] cfg_wdata;

  dfs_in_if  text_if ();
  dfs_out_if piece_if ();

  delimiter_field_splitter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .text_if    (text_if),
    .piece_if   (piece_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // shadow registers and splitter state
  logic [63:0] dl_bytes    = '0;
  logic [3:0]  dl_length   = 4'd1;
  logic        drop_empty  = 1'b0;
  logic [3:0]  match_cnt   = '0;
  logic [15:0] byte_pos    = '0;
  logic [15:0] piece_base  = '0;
  logic [15:0] piece_count = '0;

  piece_t expected_pieces[$];
  row_t   stim_table[$];
  bit     idle_on = 1'b1;
  int     err_count      = 0;
  int     bytes_sent     = 0;
  int     pieces_checked = 0;
  int     reg_writes     = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 1_500_000);
    $display("FAIL delimiter_field_splitter");
    $finish;
  end

  function automatic logic [3:0] eff_length();
    return (dl_length > MaxDelim) ? 4'(MaxDelim) : dl_length;
  endfunction

  function automatic piece_t take_piece(logic [15:0] start, logic [15:0] len, logic fin);
    piece_t pc;
    pc = {start, len, piece_count, fin};
    piece_count = piece_count + 16'd1;
    return pc;
  endfunction

  // advances the splitter state by one byte and returns the pieces it closes
  function automatic void split_byte(input logic [7:0] b, input logic fin,
                                     input logic [15:0] tlen, output int n,
                                     output piece_t p0, output piece_t p1);
    logic [3:0]  dlen;
    logic        allow;
    logic [15:0] pos;
    logic [15:0] len;
    logic [15:0] start;
    piece_t      pc;
    dlen  = eff_length();
    allow = (dlen != 0) && ({12'd0, dlen} < tlen);
    pos   = byte_pos;
    n     = 0;
    p0    = '0;
    p1    = '0;
    if (dlen != 0) begin
      if (match_cnt < dlen && b == dl_bytes[8*match_cnt[2:0] +: 8]) begin
        match_cnt = match_cnt + 4'd1;
      end else begin
        // restart: the same byte is tried against the first delimiter byte
        match_cnt = (b == dl_bytes[7:0]) ? 4'd1 : 4'd0;
      end
      if (match_cnt >= dlen) begin
        len        = pos + 16'd1 - {12'd0, dlen} - piece_base;
        start      = piece_base;
        match_cnt  = '0;
        piece_base = pos + 16'd1;
        if (allow && !(len == 0 && drop_empty)) begin
          p0 = take_piece(start, len, 1'b0);
          n  = 1;
        end
      end
    end
    if (fin) begin
      len = pos + 16'd1 - piece_base;
      if (allow && !(len == 0 && drop_empty)) begin
        pc = take_piece(piece_base, len, 1'b1);
        if (n == 0) p0 = pc;
        else p1 = pc;
        n++;
      end
      match_cnt   = '0;
      byte_pos    = '0;
      piece_base  = '0;
      piece_count = '0;
    end else begin
      byte_pos = pos + 16'd1;
    end
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [3:0] dlen;
    int         r;
    dlen = eff_length();
    r    = $urandom_range(0, 9);
    if (r < 4) return dl_bytes[8*match_cnt[2:0] +: 8];
    if (r < 6) return dl_bytes[8*$urandom_range(0, (dlen == 0) ? 7 : dlen - 1) +: 8];
    if (r == 6) return FillerBytes[8*$urandom_range(0, 3) +: 8];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send(row_t r);
    int     n;
    piece_t p0;
    piece_t p1;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      text_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    text_if.valid       <= 1'b1;
    text_if.text_byte   <= r.text_byte;
    text_if.final_byte  <= r.final_byte;
    text_if.text_length <= r.text_length;
    do @(posedge clk_i); while (!text_if.ready);
    bytes_sent++;
    split_byte(r.text_byte, r.final_byte, r.text_length, n, p0, p1);
    if (r.golden_n >= 0) begin
      n  = r.golden_n;
      p0 = r.g0;
      p1 = r.g1;
    end
    if (n > 0) expected_pieces.push_back(p0);
    if (n > 1) expected_pieces.push_back(p1);
  endtask

  // stop the stream, wait for every piece, then let the pipeline go quiet
  task automatic settle_block();
    text_if.valid <= 1'b0;
    while (expected_pieces.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] data);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_DELIM_BYTES:  dl_bytes   = data;
      CFG_DELIM_LENGTH: dl_length  = data[3:0];
      CFG_IGNORE_EMPTY: drop_empty = data[0];
      default: ;
    endcase
  endtask

  task automatic pick_config();
    logic [63:0] data;
    logic [7:0]  fill;
    int          r;
    r = $urandom_range(0, 3);
    data = {$urandom, $urandom};
    if (r == 1) begin
      // two close byte values give overlapping partial matches
      for (int k = 0; k < 8; k++) data[8*k +: 8] = FillerBytes[8*$urandom_range(0, 1) +: 8];
    end else if (r == 2) begin
      fill = 8'($urandom_range(0, 255));
      data = {8{fill}};
    end else if (r == 3) begin
      data = $urandom_range(0, 1) ? '1 : '0;
    end
    write_reg(CFG_DELIM_BYTES, data);
    data = {$urandom, $urandom};
    r = $urandom_range(0, 9);
    if (r == 0) data[3:0] = 4'd0;
    else if (r == 1) data[3:0] = 4'($urandom_range(9, 15));
    else if (r == 2) data[3:0] = 4'd8;
    else data[3:0] = 4'($urandom_range(1, 8));
    write_reg(CFG_DELIM_LENGTH, data);
    write_reg(CFG_IGNORE_EMPTY, {$urandom, $urandom});
  endtask

  task automatic run_phase(int budget, bit quiet_phase, bit force_pause);
    int          sent;
    int          len;
    int          kind;
    logic [15:0] tlen;
    bit          paused;
    row_t        r;
    settle_block();
    pick_config();
    idle_on  = !quiet_phase && ($urandom_range(0, 3) != 0);
    sent     = 0;
    paused   = 1'b0;
    r.kind   = ROW_BYTE;
    r.idx    = CFG_DELIM_BYTES;
    r.wdata  = '0;
    r.golden_n = -1;
    r.g0     = '0;
    r.g1     = '0;
    while (sent < budget) begin
      kind = $urandom_range(0, 9);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 16);
      tlen = 16'(len);
      if (kind == 7) begin
        tlen = 16'($urandom_range(0, 65535));
      end else if (kind == 8) begin
        // text about as short as the delimiter
        len  = $urandom_range(1, 10);
        tlen = 16'($urandom_range(0, 9));
      end
      for (int i = 0; i < len; i++) begin
        r.text_byte   = pick_byte();
        r.final_byte  = (kind != 9) && (i == len - 1);
        r.text_length = tlen;
        send(r);
      end
      sent += len;
      if (!paused && sent >= budget / 2 && (force_pause || $urandom_range(0, 1) == 1)) begin
        settle_block();
        paused = 1'b1;
      end
    end
  endtask

  task automatic add_cfg(cfg_idx_e idx, logic [63:0] data);
    row_t r;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.wdata = data;
    r.text_byte = '0;
    r.final_byte = 1'b0;
    r.text_length = '0;
    r.golden_n = -1;
    r.g0 = '0;
    r.g1 = '0;
    stim_table.push_back(r);
  endtask

  task automatic add_byte(logic [7:0] b, logic fin, logic [15:0] tlen, int n,
                          piece_t g0, piece_t g1);
    row_t r;
    r.kind = ROW_BYTE;
    r.idx = CFG_DELIM_BYTES;
    r.wdata = '0;
    r.text_byte = b;
    r.final_byte = fin;
    r.text_length = tlen;
    r.golden_n = n;
    r.g0 = g0;
    r.g1 = g1;
    stim_table.push_back(r);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= MaxReports)
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : piece_check
    piece_t want;
    if (rst_ni && piece_if.valid && piece_if.ready) begin
      if (expected_pieces.size() == 0) begin
        err_count++;
        if (err_count <= MaxReports)
          $display("%0t: unexpected piece expected none actual start %0d length %0d",
                   $time, piece_if.piece_start, piece_if.piece_length);
      end else begin
        want = expected_pieces.pop_front();
        pieces_checked++;
        check_field("piece_start", want.piece_start, piece_if.piece_start);
        check_field("piece_length", want.piece_length, piece_if.piece_length);
        check_field("piece_number", want.piece_number, piece_if.piece_number);
        check_field("final_piece", 16'(want.final_piece), 16'(piece_if.final_piece));
      end
    end
  end

  initial begin
    piece_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        piece_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      piece_if.ready <= 1'b1;
    end
  end

  initial begin
    row_t r;
    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_idx             <= CFG_DELIM_BYTES;
    cfg_wdata           <= '0;
    text_if.valid       <= 1'b0;
    text_if.text_byte   <= '0;
    text_if.final_byte  <= 1'b0;
    text_if.text_length <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset delimiter is one zero byte
    add_byte(8'h61, 1'b0, 16'd3, 0, '0, '0);
    add_byte(8'h00, 1'b0, 16'd3, 1, {16'd0, 16'd1, 16'd0, 1'b0}, '0);
    add_byte(8'h62, 1'b1, 16'd3, 1, {16'd2, 16'd1, 16'd1, 1'b1}, '0);
    // text no longer than the delimiter
    add_byte(8'h00, 1'b1, 16'd1, 0, '0, '0);
    // longest text length, delimiter piece plus empty trailing piece
    add_byte(8'hFF, 1'b0, 16'hFFFF, 0, '0, '0);
    add_byte(8'h00, 1'b1, 16'hFFFF, 2, {16'd0, 16'd1, 16'd0, 1'b0},
             {16'd2, 16'd0, 16'd1, 1'b1});
    // two-byte delimiter, mismatch after a partial match restarts on the same byte
    add_cfg(CFG_DELIM_BYTES, 64'h6261);
    add_cfg(CFG_DELIM_LENGTH, 64'd2);
    add_byte(8'h78, 1'b0, 16'd5, -1, '0, '0);
    add_byte(8'h61, 1'b0, 16'd5, -1, '0, '0);
    add_byte(8'h61, 1'b0, 16'd5, -1, '0, '0);
    add_byte(8'h62, 1'b0, 16'd5, -1, '0, '0);
    add_byte(8'h63, 1'b1, 16'd5, -1, '0, '0);
    // every piece empty and dropped
    add_cfg(CFG_IGNORE_EMPTY, 64'd1);
    add_byte(8'h61, 1'b0, 16'd4, -1, '0, '0);
    add_byte(8'h62, 1'b0, 16'd4, -1, '0, '0);
    add_byte(8'h61, 1'b0, 16'd4, -1, '0, '0);
    add_byte(8'h62, 1'b1, 16'd4, -1, '0, '0);
    // zero delimiter length never emits
    add_cfg(CFG_DELIM_LENGTH, 64'd0);
    add_byte(8'h61, 1'b1, 16'd9, -1, '0, '0);
    // length above the maximum acts as eight, all-ones delimiter
    add_cfg(CFG_DELIM_BYTES, '1);
    add_cfg(CFG_DELIM_LENGTH, 64'd15);
    for (int i = 0; i < 8; i++) add_byte(8'hFF, 1'b0, 16'd9, -1, '0, '0);
    add_byte(8'h01, 1'b1, 16'd9, -1, '0, '0);

    foreach (stim_table[i]) begin
      r = stim_table[i];
      if (r.kind == ROW_CFG) begin
        settle_block();
        write_reg(r.idx, r.wdata);
      end else begin
        send(r);
      end
    end

    for (int p = 0; p < 12; p++) run_phase(100, p == 11, p == 0);

    // one text with sparse letters between zero delimiters, no idling
    settle_block();
    write_reg(CFG_DELIM_BYTES, '0);
    write_reg(CFG_DELIM_LENGTH, 64'd1);
    write_reg(CFG_IGNORE_EMPTY, 64'd0);
    idle_on = 1'b0;
    r.kind = ROW_BYTE;
    r.idx = CFG_DELIM_BYTES;
    r.wdata = '0;
    r.golden_n = -1;
    r.g0 = '0;
    r.g1 = '0;
    r.text_length = 16'hFFFF;
    for (int i = 0; i < SweepBytes; i++) begin
      r.text_byte  = (i % 7 == 0) ? 8'h41 : 8'h00;
      r.final_byte = (i == SweepBytes - 1);
      send(r);
    end

    settle_block();
    $display("run covered %0d text bytes, %0d pieces, %0d register writes", bytes_sent,
             pieces_checked, reg_writes);
    $display("delimiter lengths 0 to 15, empty-piece dropping, short texts, stalls");
    if (err_count == 0) begin
      $display("PASS delimiter_field_splitter");
    end else begin
      $display("FAIL delimiter_field_splitter");
    end
    $finish;
  end

endmodule
